// File: hdl/bspline_basis_eval_top_macros.svh
// Assertion macros used by the B-spline basis evaluator back end.
`ifndef BSPLINE_BASIS_EVAL_TOP_MACROS_SVH
`define BSPLINE_BASIS_EVAL_TOP_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define BBE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Checks that cons holds in the cycle after ante holds.
`define BBE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: hdl/bbe_pkg.sv
// Types, constants and helpers shared by the B-spline basis evaluator.
package bbe_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	localparam logic REG_SPLINE_ORDER = 1'b0;
	localparam logic REG_KNOT_COUNT   = 1'b1;

	localparam logic [3:0]  SPLINE_ORDER_RST = 4'd4;
	localparam logic [6:0]  KNOT_COUNT_RST   = 7'd8;
	localparam logic [16:0] ONE_Q16          = 17'd65536;

	localparam int QUEUE_DEPTH = 2;
	localparam int DIFFW       = 33;
	localparam int DENW        = 34;
	localparam int PRODW       = 51;
	localparam int QSHIFT      = 18;
	localparam int QUOW        = 20;
	localparam int SUMW        = 21;

	typedef struct packed {
		logic              cmd;
		logic [5:0]        knot_slot;
		logic signed [31:0] knot_value;
		logic signed [31:0] x_value;
	} in_item_t;

	typedef struct packed {
		logic [5:0]  basis_column;
		logic [16:0] basis_value;
		logic        zero_divide;
		logic        last_value;
	} out_item_t;

	typedef enum logic {
		KIND_LOAD,
		KIND_EVAL
	} item_kind_t;

	typedef struct packed {
		logic       valid;
		item_kind_t kind;
		in_item_t   item;
	} fb_item_t;

	typedef struct packed {
		logic                    start;
		logic signed [PRODW-1:0] num;
		logic signed [DENW-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [QUOW-1:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH,
		ST_SRCH_W,
		ST_LAST_W,
		ST_DR_RD,
		ST_DL_RD,
		ST_DL_W,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_UPD,
		ST_EMIT
	} back_state_t;

	// Clamps a signed sum to the unit interval in Q1.16.
	function automatic logic [16:0] sat_unit(input logic signed [SUMW-1:0] v);
		logic [16:0] r;
		if (v < 0) begin
			r = 17'd0;
		end else if (v > $signed({4'b0, ONE_Q16})) begin
			r = ONE_Q16;
		end else begin
			r = v[16:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/bbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hdl/bbe_front.sv
// Front end: accepts input transactions, classifies them and queues them for the back end.
module bbe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  bbe_pkg::in_item_t in_item,
	output bbe_pkg::fb_item_t fb,
	input  logic             fb_pop
);
	import bbe_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	fb_item_t          ent_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [PW:0]       cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = fb_pop && (cnt_q != '0);

	always_comb begin
		fb       = ent_q[rd_q];
		fb.valid = (cnt_q != '0);
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q].valid <= 1'b1;
			ent_q[wr_q].kind  <= (in_item.cmd == CMD_LOAD) ? KIND_LOAD : KIND_EVAL;
			ent_q[wr_q].item  <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end
endmodule

// File: hdl/bbe_div.sv
// Restoring divider that yields a signed quotient truncated toward zero and saturated.
module bbe_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bbe_pkg::div_req_t req,
	output bbe_pkg::div_rsp_t rsp
);
	import bbe_pkg::*;

	localparam int CNTW = $clog2(QSHIFT + 1);

	logic [PRODW-1:0]  rem_q;
	logic [PRODW-1:0]  dsh_q;
	logic [QSHIFT:0]   quo_q;
	logic              neg_q;
	logic              run_q;
	logic              chk_q;
	logic              done_q;
	logic [CNTW-1:0]   cnt_q;
	logic [PRODW-1:0]  num_abs;
	logic [DENW-1:0]   den_abs;

	assign num_abs = req.num[PRODW-1] ? PRODW'(-req.num) : PRODW'(req.num);
	assign den_abs = req.den[DENW-1] ? DENW'(-req.den) : DENW'(req.den);

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= num_abs;
			dsh_q <= {den_abs, {(QSHIFT-1){1'b0}}};
			neg_q <= req.num[PRODW-1] ^ req.den[DENW-1];
			quo_q <= '0;
		end else if (run_q) begin
			if (chk_q) begin
				// A quotient this large saturates the result anyway.
				if ({1'b0, rem_q} >= {dsh_q, 1'b0}) begin
					quo_q <= {1'b1, {QSHIFT{1'b0}}};
				end
			end else begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[QSHIFT-1:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QSHIFT-1:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			chk_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				chk_q <= 1'b1;
				cnt_q <= CNTW'(QSHIFT);
			end else if (run_q) begin
				if (chk_q) begin
					chk_q <= 1'b0;
					if ({1'b0, rem_q} >= {dsh_q, 1'b0}) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end
endmodule

// File: hdl/bbe_back.sv
// Back end: knot table, interval search, Cox-de Boor triangle and result register.
`include "bspline_basis_eval_top_macros.svh"
module bbe_back #(
	parameter int MAX_KNOTS = 64,
	parameter int MAX_ORDER = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bbe_pkg::fb_item_t  fb,
	output logic               fb_pop,
	input  logic [3:0]         spline_order,
	input  logic [6:0]         knot_count,
	output logic               empty,
	input  logic               pop,
	output bbe_pkg::out_item_t out_item
);
	import bbe_pkg::*;

	localparam int AW  = $clog2(MAX_KNOTS);
	localparam int NW  = $clog2(MAX_KNOTS + 1);
	localparam int MW  = $clog2(MAX_ORDER + 1);
	localparam int SW  = (AW > 6) ? AW : 6;
	localparam int CW0 = $clog2(MAX_KNOTS + 2 * MAX_ORDER + 2) + 2;
	localparam int CW  = (CW0 < 8) ? 8 : CW0;

	back_state_t             st_q, st_d;
	logic signed [31:0]      x_q;
	logic [MW-1:0]           m_q, j_q, r_q, e_q;
	logic [NW-1:0]           n_q, l_q, u_q;
	logic [16:0]             saved_q;
	logic                    zdiv_q;
	logic                    da_q, db_q;
	logic [16:0]             q_q  [1:MAX_ORDER];
	logic signed [DIFFW-1:0] dr_q [1:MAX_ORDER];
	logic signed [DIFFW-1:0] dl_q [1:MAX_ORDER];
	logic signed [PRODW-1:0] pa_s1, pb_s1;
	logic signed [DENW-1:0]  den_s1;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr, ram_raddr;
	logic [31:0]             ram_rdata;
	logic signed [31:0]      knot_rd;
	logic [SW-1:0]           slot_ext;
	logic [NW:0]             sum_lu;
	logic [NW-1:0]           mid;
	logic [MW-1:0]           m_clamp, q_idx, dl_idx, jp1;
	logic [NW-1:0]           n_clamp;
	logic signed [DIFFW-1:0] dr_sel, dl_sel;
	logic signed [17:0]      q_sel;
	logic signed [PRODW-1:0] prod_a, prod_b;
	logic signed [QUOW-1:0]  a_val, b_val;
	logic [16:0]             q_new, b_new;
	logic signed [CW-1:0]    col_c, lim_c;
	logic [5:0]              col_out;
	logic                    out_free;
	div_req_t                req;
	div_rsp_t                rsp_a, rsp_b;

	// Gives the table address of one-based knot k, with the index held to 1..n.
	function automatic logic [AW-1:0] knot_addr(input logic signed [CW-1:0] k,
		input logic [NW-1:0] n);
		logic signed [CW-1:0] kk;
		kk = k;
		if (kk < CW'(1)) begin
			kk = CW'(1);
		end else if (kk > $signed(CW'(n))) begin
			kk = CW'(n);
		end
		return AW'(kk - CW'(1));
	endfunction

	bbe_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (fb.item.knot_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bbe_div u_div_a (.clk(clk), .arst_n(arst_n), .req(req),
		.rsp(rsp_a));
	bbe_div u_div_b (.clk(clk), .arst_n(arst_n),
		.req('{start: req.start, num: pb_s1, den: den_s1}), .rsp(rsp_b));

	assign knot_rd   = $signed(ram_rdata);
	assign slot_ext  = SW'(fb.item.knot_slot);
	assign ram_waddr = slot_ext[AW-1:0];
	assign sum_lu    = {1'b0, u_q} + {1'b0, l_q};
	assign mid       = sum_lu[NW:1];
	assign jp1       = j_q + 1'b1;
	assign dl_idx    = j_q + 1'b1 - r_q;
	assign q_idx     = (st_q == ST_EMIT) ? e_q : r_q;
	assign dr_sel    = dr_q[r_q];
	assign dl_sel    = dl_q[dl_idx];
	assign q_sel     = $signed({1'b0, q_q[q_idx]});
	assign prod_a    = dr_sel * q_sel;
	assign prod_b    = dl_sel * q_sel;
	assign a_val     = (den_s1 == '0) ? '0 : rsp_a.quot;
	assign b_val     = (den_s1 == '0) ? '0 : rsp_b.quot;
	assign q_new     = sat_unit(SUMW'($signed({1'b0, saved_q})) + SUMW'(a_val));
	assign b_new     = sat_unit(SUMW'(b_val));
	assign out_free  = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign out_item  = out_q;

	assign req.start = (st_q == ST_DIV_GO) && (den_s1 != '0);
	assign req.num   = pa_s1;
	assign req.den   = den_s1;

	always_comb begin
		if (spline_order == 4'd0) begin
			m_clamp = MW'(1);
		end else if (32'(spline_order) > MAX_ORDER) begin
			m_clamp = MW'(MAX_ORDER);
		end else begin
			m_clamp = MW'(spline_order);
		end
		if (knot_count < 7'd2) begin
			n_clamp = NW'(2);
		end else if (32'(knot_count) > MAX_KNOTS) begin
			n_clamp = NW'(MAX_KNOTS);
		end else begin
			n_clamp = NW'(knot_count);
		end
	end

	// Column of the basis value being emitted, held to the last full span.
	always_comb begin
		col_c = CW'(l_q) - CW'(m_q) + CW'(e_q);
		lim_c = CW'(n_q) - CW'(m_q);
		if (col_c > lim_c) begin
			col_c = lim_c;
		end
		col_c = col_c - CW'(1);
		if (col_c < 0) begin
			col_out = 6'd0;
		end else if (col_c > CW'(63)) begin
			col_out = 6'd63;
		end else begin
			col_out = col_c[5:0];
		end
	end

	always_comb begin
		st_d      = st_q;
		fb_pop    = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = '0;
		case (st_q)
			ST_IDLE: begin
				if (fb.valid) begin
					fb_pop = 1'b1;
					if (fb.kind == KIND_LOAD) begin
						ram_we = (32'(fb.item.knot_slot) < MAX_KNOTS);
					end else begin
						st_d = ST_SRCH;
					end
				end
			end
			ST_SRCH: begin
				if (u_q - l_q > NW'(1)) begin
					ram_raddr = AW'(mid - 1'b1);
					st_d      = ST_SRCH_W;
				end else begin
					ram_raddr = AW'(n_q - 1'b1);
					st_d      = ST_LAST_W;
				end
			end
			ST_SRCH_W: st_d = ST_SRCH;
			ST_LAST_W: begin
				if ((x_q == knot_rd) || (m_q == MW'(1))) begin
					st_d = ST_EMIT;
				end else begin
					st_d = ST_DR_RD;
				end
			end
			ST_DR_RD: begin
				ram_raddr = knot_addr(CW'(l_q) + CW'(j_q), n_q);
				st_d      = ST_DL_RD;
			end
			ST_DL_RD: begin
				ram_raddr = knot_addr(CW'(l_q) + CW'(1) - CW'(j_q), n_q);
				st_d      = ST_DL_W;
			end
			ST_DL_W: st_d = ST_MUL;
			ST_MUL:  st_d = ST_DIV_GO;
			ST_DIV_GO: begin
				st_d = (den_s1 == '0) ? ST_UPD : ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				// A saturating quotient can finish early, so both dividers are awaited.
				if ((rsp_a.done || da_q) && (rsp_b.done || db_q)) begin
					st_d = ST_UPD;
				end
			end
			ST_UPD: begin
				if (r_q == j_q) begin
					st_d = (jp1 == m_q) ? ST_EMIT : ST_DR_RD;
				end else begin
					st_d = ST_MUL;
				end
			end
			ST_EMIT: begin
				if (out_free && (e_q == m_q)) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				x_q     <= fb.item.x_value;
				m_q     <= m_clamp;
				n_q     <= n_clamp;
				l_q     <= NW'(1);
				u_q     <= n_clamp;
				zdiv_q  <= 1'b0;
			end
			ST_SRCH_W: begin
				if (x_q < knot_rd) begin
					u_q <= mid;
				end else begin
					l_q <= mid;
				end
			end
			ST_LAST_W: begin
				for (int i = 1; i <= MAX_ORDER; i++) begin
					q_q[i] <= '0;
				end
				if (x_q == knot_rd) begin
					q_q[m_q] <= ONE_Q16;
				end else begin
					q_q[1] <= ONE_Q16;
				end
				j_q <= MW'(1);
				e_q <= MW'(1);
			end
			ST_DL_RD: begin
				dr_q[j_q] <= $signed({knot_rd[31], knot_rd}) - $signed({x_q[31], x_q});
			end
			ST_DL_W: begin
				dl_q[j_q] <= $signed({x_q[31], x_q}) - $signed({knot_rd[31], knot_rd});
				r_q       <= MW'(1);
				saved_q   <= '0;
			end
			ST_MUL: begin
				den_s1 <= DENW'(dr_sel) + DENW'(dl_sel);
				pa_s1  <= prod_a;
				pb_s1  <= prod_b;
			end
			ST_DIV_GO: begin
				da_q <= 1'b0;
				db_q <= 1'b0;
				if (den_s1 == '0) begin
					zdiv_q <= 1'b1;
				end
			end
			ST_DIV_WAIT: begin
				if (rsp_a.done) begin
					da_q <= 1'b1;
				end
				if (rsp_b.done) begin
					db_q <= 1'b1;
				end
			end
			ST_UPD: begin
				q_q[r_q] <= q_new;
				saved_q  <= b_new;
				if (r_q == j_q) begin
					q_q[jp1] <= b_new;
					j_q      <= jp1;
				end else begin
					r_q <= r_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					e_q <= e_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if ((st_q == ST_EMIT) && out_free) begin
			out_q.basis_column <= col_out;
			out_q.basis_value  <= q_q[q_idx];
			out_q.zero_divide  <= zdiv_q;
			out_q.last_value   <= (e_q == m_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((st_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	`BBE_ASSERT_NOW(a_search_bounds, st_q == ST_SRCH, l_q < u_q, "search bounds crossed")
	`BBE_ASSERT_NOW(a_tri_index, st_q == ST_MUL, (r_q >= MW'(1)) && (r_q <= j_q) && (j_q < m_q), "triangle index out of range")
	`BBE_ASSERT_NOW(a_div_done, rsp_a.done, st_q == ST_DIV_WAIT, "divider finished outside its wait")
	`BBE_ASSERT_NEXT(a_emit_last, (st_q == ST_EMIT) && out_free && (e_q == m_q), out_valid_q && out_q.last_value, "final value not flagged")
endmodule

// File: hdl/bspline_basis_eval_top.sv
// B-spline basis evaluator: top level with the configuration registers.
// Load transactions write one Q16.16 knot into the knot table while the back end stays in
// its idle state. An evaluate transaction finds the knot interval by bisection, each step
// reading one knot and then halving the interval, then runs the Cox-de Boor triangle: each
// of the m*(m-1)/2 terms waits on the bit-serial divider, which yields 18 quotient bits one
// per cycle, and each triangle row first makes two knot-table reads. The m basis values
// then leave one per cycle while the consumer pops each one as it arrives. A two-entry queue
// before the back end and a result register after it let the input and output sides stall
// on their own. Registers: spline_order at byte 0, knot_count at byte 4.
module bspline_basis_eval_top #(
	parameter int MAX_KNOTS = 64,
	parameter int MAX_ORDER = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  bbe_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output bbe_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import bbe_pkg::*;

	logic [3:0] spline_order_q;
	logic [6:0] knot_count_q;
	logic       cfg_wr;
	fb_item_t   fb;
	logic       fb_pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spline_order_q <= SPLINE_ORDER_RST;
			knot_count_q   <= KNOT_COUNT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SPLINE_ORDER: spline_order_q <= pwdata[3:0];
				REG_KNOT_COUNT:   knot_count_q   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SPLINE_ORDER: prdata = {28'd0, spline_order_q};
			REG_KNOT_COUNT:   prdata = {25'd0, knot_count_q};
			default:          prdata = '0;
		endcase
	end

	bbe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.fb      (fb),
		.fb_pop  (fb_pop)
	);

	bbe_back #(.MAX_KNOTS(MAX_KNOTS), .MAX_ORDER(MAX_ORDER)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fb           (fb),
		.fb_pop       (fb_pop),
		.spline_order (spline_order_q),
		.knot_count   (knot_count_q),
		.empty        (empty),
		.pop          (pop),
		.out_item     (out_item)
	);
endmodule
